@@ src/rkdf_pkg.sv @@
// Shared widths, payload types and defaults for the record key dedup filter.
package rkdf_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 128;

   localparam int KEY_W0_W = 64;
   localparam int KEY_W1_W = 64;
   localparam int KEY_W2_W = 24;
   localparam int INDEX_W  = 7;
   localparam int COUNT_W  = 8;

   typedef struct packed {
      logic [KEY_W2_W-1:0] word_2;
      logic [KEY_W1_W-1:0] word_1;
      logic [KEY_W0_W-1:0] word_0;
   } key_type;

endpackage

@@ src/rkdf_if.sv @@
// Record and result channel interfaces of the record key dedup filter.
interface rkdf_req_if
   import rkdf_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [KEY_W0_W-1:0] key_word_0;
   logic [KEY_W1_W-1:0] key_word_1;
   logic [KEY_W2_W-1:0] key_word_2;
   logic [INDEX_W-1:0]  record_index;
   logic                last_record;

   modport source (output valid, key_word_0, key_word_1, key_word_2, record_index,
                   last_record, input ready);
   modport sink   (input valid, key_word_0, key_word_1, key_word_2, record_index,
                   last_record, output ready);
endinterface

interface rkdf_rsp_if
   import rkdf_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               is_duplicate;
   logic               table_full;
   logic [INDEX_W-1:0] kept_index;
   logic [COUNT_W-1:0] unique_count;
   logic               end_of_list;

   modport source (output valid, is_duplicate, table_full, kept_index, unique_count,
                   end_of_list, input ready);
   modport sink   (input valid, is_duplicate, table_full, kept_index, unique_count,
                   end_of_list, output ready);
endinterface

@@ src/record_key_dedup_filter_core.sv @@
// Top level of the record key dedup filter: key table, scan sequencer, result register.
//
// Records enter on req_if, one beat per record: a 19-byte key in three words,
// the record index and a last-record flag. Each beat yields exactly one result
// beat on rsp_if: duplicate flag, table-full flag, echoed index, count of
// distinct keys kept so far and the echoed last flag.
// A record is accepted only while the sequencer is idle. The key is then
// compared against the kept keys, read one per cycle from a single-port key
// memory with registered read data, through the scan, drain and done states;
// an empty table goes straight to done. A new key is written, if the table has
// room, at the end of the scan; the record flagged last empties the table
// after its result is formed.
// The result sits in an output register; a new record is accepted while it
// waits, but the next result holds the sequencer until rsp_if.ready frees it.
// Synchronous reset empties the table and drops any pending result; no
// clearing pass is needed since only entries below the kept count are read.
module record_key_dedup_filter_core
   import rkdf_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   rkdf_req_if.sink    req_if,
   rkdf_rsp_if.source  rsp_if
);

   localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW  = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   key_type             key_store [TABLE_DEPTH];
   key_type             key_ff, key_in;
   key_type             rd_data_ff;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic                last_ff, last_in;
   logic [AddrW-1:0]    addr_ff, addr_in;
   logic [CntW-1:0]     kept_total_ff, kept_total_in;
   logic                rd_valid_ff, rd_valid_in;
   logic                match_ff, match_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                dup_ff, dup_in;
   logic                full_ff, full_in;
   logic [INDEX_W-1:0]  kept_index_ff, kept_index_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                eol_ff, eol_in;

   logic                req_fire;
   logic                done_fire;
   logic                has_room;
   logic                do_store;
   logic                scan_last;
   logic [CntW-1:0]     kept_next;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign done_fire    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);
   assign has_room     = (kept_total_ff < CntW'(TABLE_DEPTH));
   assign do_store     = done_fire && !match_ff && has_room;
   assign kept_next    = do_store ? kept_total_ff + CntW'(1) : kept_total_ff;
   assign scan_last    = (CntW'(addr_ff) + CntW'(1) == kept_total_ff);

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      index_in      = index_ff;
      last_in       = last_ff;
      addr_in       = addr_ff;
      kept_total_in = kept_total_ff;
      rd_valid_in   = 1'b0;
      match_in      = match_ff;
      rsp_valid_in  = rsp_if.ready ? 1'b0 : rsp_valid_ff;
      dup_in        = dup_ff;
      full_in       = full_ff;
      kept_index_in = kept_index_ff;
      count_in      = count_ff;
      eol_in        = eol_ff;

      if (rd_valid_ff && (rd_data_ff == key_ff)) begin
         match_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_in   = '{word_2: req_if.key_word_2, word_1: req_if.key_word_1,
                            word_0: req_if.key_word_0};
               index_in = req_if.record_index;
               last_in  = req_if.last_record;
               addr_in  = '0;
               match_in = 1'b0;
               state_in = (kept_total_ff == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            addr_in     = AddrW'(addr_ff + AddrW'(1));
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (done_fire) begin
               rsp_valid_in  = 1'b1;
               dup_in        = match_ff;
               full_in       = !match_ff && !has_room;
               kept_index_in = index_ff;
               count_in      = COUNT_W'(kept_next);
               eol_in        = last_ff;
               kept_total_in = last_ff ? '0 : kept_next;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         kept_total_ff <= '0;
         rd_valid_ff   <= 1'b0;
         match_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         kept_total_ff <= kept_total_in;
         rd_valid_ff   <= rd_valid_in;
         match_ff      <= match_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      index_ff      <= index_in;
      last_ff       <= last_in;
      addr_ff       <= addr_in;
      dup_ff        <= dup_in;
      full_ff       <= full_in;
      kept_index_ff <= kept_index_in;
      count_ff      <= count_in;
      eol_ff        <= eol_in;
   end

   always_ff @(posedge clock) begin
      if (do_store) begin
         key_store[kept_total_ff[AddrW-1:0]] <= key_ff;
      end
      rd_data_ff <= key_store[addr_ff];
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.is_duplicate = dup_ff;
   assign rsp_if.table_full   = full_ff;
   assign rsp_if.kept_index   = kept_index_ff;
   assign rsp_if.unique_count = count_ff;
   assign rsp_if.end_of_list  = eol_ff;

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CntW'(addr_ff) < kept_total_ff))
      else $error("scan address beyond kept keys");

   a_kept_bounded: assert property (@(posedge clock) disable iff (reset)
      kept_total_ff <= CntW'(TABLE_DEPTH))
      else $error("kept count above table depth");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (done_fire && last_ff) |=> (kept_total_ff == '0))
      else $error("table not emptied after last record");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(dup_ff && full_ff))
      else $error("duplicate and full flagged together");

endmodule
